>>> sv/lbcd_pkg.sv
// Shared constants and codes for the LRU block cache directory.
package lbcd_pkg;

  // Directory geometry
  localparam int ENTRIES = 256;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int FILL_W  = IDX_W + 1;

  // Field widths
  localparam int TAG_W   = 64;
  localparam int STAMP_W = 64;
  localparam int SLOT_W  = 8;
  localparam int ENTRY_W = STAMP_W + TAG_W;

  // Command codes
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // Start value of the oldest-stamp search
  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

endpackage

>>> sv/lbcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lbcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/lru_block_cache_directory.sv
// Top level of the LRU block cache directory: scan sequencer around one entry RAM.
//
//  channel  | dir | tdata          | tuser        | handshake
//  ---------+-----+----------------+--------------+-----------------------
//  in_      | in  | blk_num [63:0] | command [0]  | in_tvalid / in_tready
//  out_     | out | slot [7:0]     | hit [0]      | out_tvalid / out_tready
//
// One request is in work at a time. A lookup scans the filled slots one RAM read
// per cycle and stops at the first match, or misses at once when empty. An insert
// into a free slot skips the scan; an insert into a full directory scans every
// stamp. Valid slots always form a prefix, so a fill count replaces per-entry
// valid bits and no clearing pass follows reset. A finished result waits in the
// output register; a new request is taken while it waits.
module lru_block_cache_directory
  import lbcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [TAG_W-1:0]  in_tdata,   // [63:0] blk_num
  input  logic [0:0]        in_tuser,   // [0] command
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [SLOT_W-1:0] out_tdata,  // [7:0] slot
  output logic [0:0]        out_tuser   // [0] hit
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WRITE, ST_FINISH} state_t;

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(ENTRIES);

  state_t              state_r, state_nxt;
  logic                cmd_r, cmd_nxt;
  logic [TAG_W-1:0]    id_r, id_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [STAMP_W-1:0]  stamp_r, stamp_nxt;
  logic [IDX_W-1:0]    addr_r, addr_nxt;
  logic                issue_r, issue_nxt;
  logic                dvld_r, dvld_nxt;
  logic [IDX_W-1:0]    didx_r, didx_nxt;
  logic [STAMP_W-1:0]  oldest_r, oldest_nxt;
  logic [IDX_W-1:0]    best_r, best_nxt;
  logic [IDX_W-1:0]    slot_r, slot_nxt;
  logic                hit_r, hit_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;

  logic                ram_we, ram_re;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  logic [TAG_W-1:0]    rd_tag;
  logic [STAMP_W-1:0]  rd_stamp;
  logic                full;
  logic [FILL_W-1:0]   fill_m1;
  logic [IDX_W-1:0]    last_idx;
  logic                older;
  logic [IDX_W+SLOT_W-1:0] slot_ext;

  // Entry store: stamp in the upper half, tag in the lower half
  lbcd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign rd_tag    = ram_rdata[TAG_W-1:0];
  assign rd_stamp  = ram_rdata[ENTRY_W-1:TAG_W];
  assign ram_wdata = {stamp_r, id_r};

  assign full     = (fill_r == FULL_CNT);
  assign fill_m1  = fill_r - 1'b1;
  assign last_idx = (cmd_r == CMD_INSERT) ? LAST_IDX : fill_m1[IDX_W-1:0];
  assign older    = (rd_stamp < oldest_r);
  assign slot_ext = {{SLOT_W{1'b0}}, slot_r};

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_slot_r;
  assign out_tuser  = out_hit_r;

  // Sequence one request: scan if needed, write back on an insert or a hit, hand off
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    fill_nxt      = fill_r;
    stamp_nxt     = stamp_r;
    addr_nxt      = addr_r;
    issue_nxt     = issue_r;
    dvld_nxt      = 1'b0;
    didx_nxt      = didx_r;
    oldest_nxt    = oldest_r;
    best_nxt      = best_r;
    slot_nxt      = slot_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_hit_nxt   = out_hit_r;
    out_slot_nxt  = out_slot_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt    = in_tuser[0];
          id_nxt     = in_tdata;
          addr_nxt   = '0;
          issue_nxt  = 1'b1;
          oldest_nxt = STAMP_MAX;
          best_nxt   = '0;
          hit_nxt    = 1'b0;
          if (in_tuser[0] == CMD_INSERT && !full) begin
            // free slot: the next one past the filled prefix
            slot_nxt  = fill_r[IDX_W-1:0];
            state_nxt = ST_WRITE;
          end else if (in_tuser[0] == CMD_LOOKUP && fill_r == '0) begin
            slot_nxt  = '0;
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // issue reads one address per cycle
        ram_re   = issue_r;
        dvld_nxt = issue_r;
        didx_nxt = addr_r;
        if (issue_r) begin
          if (addr_r == last_idx) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end
        // evaluate the entry read last cycle
        if (dvld_r) begin
          if (cmd_r == CMD_LOOKUP) begin
            if (rd_tag == id_r) begin
              hit_nxt   = 1'b1;
              slot_nxt  = didx_r;
              issue_nxt = 1'b0;
              dvld_nxt  = 1'b0;
              state_nxt = ST_WRITE;
            end else if (didx_r == last_idx) begin
              slot_nxt  = '0;
              state_nxt = ST_FINISH;
            end
          end else begin
            if (older) begin
              oldest_nxt = rd_stamp;
              best_nxt   = didx_r;
            end
            if (didx_r == last_idx) begin
              slot_nxt  = older ? didx_r : best_r;
              state_nxt = ST_WRITE;
            end
          end
        end
      end

      ST_WRITE: begin
        // write tag and stamp, advance the stamp counter
        ram_we    = 1'b1;
        stamp_nxt = stamp_r + 1'b1;
        if (cmd_r == CMD_INSERT && !full) begin
          fill_nxt = fill_r + 1'b1;
        end
        state_nxt = ST_FINISH;
      end

      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          out_slot_nxt  = slot_ext[SLOT_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      stamp_r     <= '0;
      issue_r     <= 1'b0;
      dvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      stamp_r     <= stamp_nxt;
      issue_r     <= issue_nxt;
      dvld_r      <= dvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    addr_r     <= addr_nxt;
    didx_r     <= didx_nxt;
    oldest_r   <= oldest_nxt;
    best_r     <= best_nxt;
    slot_r     <= slot_nxt;
    hit_r      <= hit_nxt;
    out_hit_r  <= out_hit_nxt;
    out_slot_r <= out_slot_nxt;
  end

endmodule

>>> sv/lbcd_chk.sv
// Port-level checker for the LRU block cache directory, bound to the top level.
module lbcd_chk
  import lbcd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [TAG_W-1:0]  in_tdata,
  input logic [0:0]        in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [SLOT_W-1:0] out_tdata,
  input logic [0:0]        out_tuser
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // An accepted request makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in work");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind lru_block_cache_directory lbcd_chk u_lbcd_chk (.*);

>>> test/lru_block_cache_directory_tb.sv
// Self-checking testbench for the LRU block cache directory.
module lru_block_cache_directory_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lbcd_pkg::*;

  localparam int RANDOM_REQS    = 800;
  localparam int CALM_TAIL      = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = ENTRIES + 40;

  typedef struct {
    logic             cmd;
    logic [TAG_W-1:0] blk_num;
    bit               wait_drain;
  } dir_req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } dir_reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [TAG_W-1:0]  in_tdata = '0;
  logic [0:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [SLOT_W-1:0] out_tdata;
  logic [0:0]        out_tuser;

  lru_block_cache_directory dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Shadow directory state
  logic [TAG_W-1:0]   shadow_tag   [ENTRIES];
  logic [STAMP_W-1:0] shadow_stamp [ENTRIES];
  bit                 shadow_valid [ENTRIES];
  logic [STAMP_W-1:0] shadow_clock;

  dir_req_t         req_q [$];
  dir_reply_t       due_replies [$];
  logic [TAG_W-1:0] known_ids [$];

  int req_total;
  int quiet_from;
  int req_sent = 0;
  int reply_seen = 0;
  int errors = 0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit send_bursty = 1'b1;
  bit recv_bursty = 1'b1;

  // Apply one request to the shadow directory and return the slot it reports.
  function automatic dir_reply_t dir_access(logic cmd, logic [TAG_W-1:0] blk_num);
    dir_reply_t         r;
    int                 pick;
    bit                 found;
    logic [STAMP_W-1:0] oldest;
    r      = '0;
    pick   = 0;
    found  = 1'b0;
    oldest = STAMP_MAX;
    if (cmd == CMD_LOOKUP) begin
      // first valid match wins
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && shadow_valid[i] && shadow_tag[i] == blk_num) begin
          found = 1'b1;
          pick  = i;
        end
      end
      if (found) begin
        shadow_stamp[pick] = shadow_clock;
        shadow_clock       = shadow_clock + 1'b1;
        r.hit              = 1'b1;
        r.slot             = pick[SLOT_W-1:0];
      end
    end else begin
      // lowest free slot, else the oldest stamp (lowest index on ties)
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found) begin
          if (!shadow_valid[i]) begin
            found = 1'b1;
            pick  = i;
          end else if (shadow_stamp[i] < oldest) begin
            oldest = shadow_stamp[i];
            pick   = i;
          end
        end
      end
      shadow_tag[pick]   = blk_num;
      shadow_valid[pick] = 1'b1;
      shadow_stamp[pick] = shadow_clock;
      shadow_clock       = shadow_clock + 1'b1;
      r.slot             = pick[SLOT_W-1:0];
    end
    return r;
  endfunction

  task automatic add_req(logic cmd, logic [TAG_W-1:0] blk_num, bit wait_drain);
    dir_req_t r;
    r.cmd        = cmd;
    r.blk_num    = blk_num;
    r.wait_drain = wait_drain;
    req_q.push_back(r);
    if (cmd == CMD_INSERT) known_ids.push_back(blk_num);
  endtask

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Reset
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Shadow reset: every slot free, stamp clock at zero
  initial begin
    for (int i = 0; i < ENTRIES; i++) shadow_valid[i] = 1'b0;
    shadow_clock = '0;
  end

  // Request driver: hold each request until taken, insert idle bursts between
  always @(posedge clk) begin : drive
    int       sent_now;
    bit       give;
    dir_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      sent_now = req_sent;
      if (in_tvalid && in_tready) begin
        due_replies.push_back(dir_access(in_tuser[0], in_tdata));
        sent_now++;
        req_sent <= sent_now;
        if ($urandom_range(0, 49) == 0) send_bursty = !send_bursty;
      end
      if (!in_tvalid || in_tready) begin
        give = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0 &&
                     !(req_q[0].wait_drain && sent_now != reply_seen)) begin
          if (send_bursty && sent_now < quiet_from && $urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(1, 15) - 1;
          end else begin
            give = 1'b1;
          end
        end
        if (give) begin
          nxt = req_q.pop_front();
          in_tdata <= nxt.blk_num;
          in_tuser <= nxt.cmd;
        end
        in_tvalid <= give;
      end
    end
  end

  // Reply monitor: check each reply against the oldest prediction, stall at random
  always @(posedge clk) begin : watch
    dir_reply_t want;
    bit         ready_nxt;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        reply_seen <= reply_seen + 1;
        if (due_replies.size() == 0) begin
          $display("%0t: unexpected reply hit=%0d slot=%0d", $time, out_tuser[0], out_tdata);
          errors++;
        end else begin
          want = due_replies.pop_front();
          if (out_tuser[0] !== want.hit) begin
            $display("%0t: hit expected %0d, got %0d", $time, want.hit, out_tuser[0]);
            errors++;
          end
          if (out_tdata !== want.slot) begin
            $display("%0t: slot expected %0d, got %0d", $time, want.slot, out_tdata);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) recv_bursty = !recv_bursty;
      if (stall_left > 0) begin
        stall_left--;
        ready_nxt = 1'b0;
      end else if (recv_bursty && req_sent < quiet_from && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        ready_nxt  = 1'b0;
      end else begin
        ready_nxt = 1'b1;
      end
      out_tready <= ready_nxt;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no request or reply moved for %0d cycles", $time, idle_cycles);
          $display("lru_block_cache_directory: mismatch");
          $finish;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    logic [TAG_W-1:0] id;
    logic             cmd;
    int               roll;
    // empty directory misses, then fill with extreme tags
    add_req(CMD_LOOKUP, '0, 1'b0);
    add_req(CMD_LOOKUP, '1, 1'b0);
    add_req(CMD_INSERT, '0, 1'b0);
    add_req(CMD_INSERT, '1, 1'b0);
    add_req(CMD_LOOKUP, '1, 1'b0);
    add_req(CMD_LOOKUP, '0, 1'b0);
    add_req(CMD_INSERT, 64'h5555_5555_5555_5555, 1'b0);
    add_req(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    // duplicate tag: lookup must report the lower slot
    add_req(CMD_INSERT, '0, 1'b0);
    add_req(CMD_LOOKUP, '0, 1'b0);
    add_req(CMD_LOOKUP, 64'h0000_0000_0000_0001, 1'b0);
    add_req(CMD_LOOKUP, 64'h8000_0000_0000_0000, 1'b0);
    add_req(CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);

    // random traffic: inserts fill the directory and then evict, lookups mostly
    // reuse tags seen before so hits and restamps shape the LRU order
    for (int n = 0; n < RANDOM_REQS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        cmd = CMD_INSERT;
        if ($urandom_range(0, 4) == 0)
          id = known_ids[$urandom_range(0, known_ids.size() - 1)];
        else
          id = {$urandom, $urandom};
      end else begin
        cmd = CMD_LOOKUP;
        if ($urandom_range(0, 3) != 0)
          id = known_ids[$urandom_range(0, known_ids.size() - 1)];
        else
          id = {$urandom, $urandom};
      end
      // let the directory drain once before random traffic starts
      add_req(cmd, id, n == 0);
    end
    req_total  = req_q.size();
    quiet_from = req_total - CALM_TAIL;

    wait (req_sent == req_total);
    wait (reply_seen == req_sent);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_replies.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, due_replies.size());
      errors++;
    end
    if (errors == 0) begin
      $display("lru_block_cache_directory: match");
    end else begin
      $display("lru_block_cache_directory: mismatch");
    end
    $finish;
  end

endmodule
